// ----- hdl/pctd_pkg.sv -----
// ----------------------------------------------------------------------------
// pctd_pkg
// Types and constants shared by the prefix-code table decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

  // longest code the datapath is built for
  localparam int MAX_CODE_BITS = 16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  localparam logic CFG_ENTRY_COUNT  = 1'b0;
  localparam logic CFG_LONGEST_CODE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  entry_index;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [7:0]  symbol_byte;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       halted;
    logic       last_in_run;
  } out_item_t;

endpackage

// ----- hdl/pctd_table.sv -----
// ----------------------------------------------------------------------------
// pctd_table
// Code table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pctd_table #(
  parameter int Depth = 256,
  parameter int Aw    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [28:0]   wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [28:0]   rdata_o
);
  logic [28:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hdl/prefix_code_table_decoder.sv -----
// ----------------------------------------------------------------------------
// prefix_code_table_decoder
// Table-driven prefix-code decoder with a sequential table scan.
// ----------------------------------------------------------------------------
// Usage: load items write the code table; data items push one byte, MSB
// first, and yield one result per decoded symbol plus a status result when
// nothing decoded or decoding halted. last_in_run marks an item's final one.
// Config writes (index 0 entry_count, 1 longest_code) only while idle.
// Flow: a load is taken while idle and gives no result. A data item is
// accepted while idle; each symbol search then scans the table once for
// every code length tried, a hit passes its symbol on in S_EMIT, and the
// item finishes in S_FIN (staying there while a status result follows a
// symbol). A single comparator steps through the table memory.
// Each symbol is held back until the next search ends, so that the final
// one can carry last_in_run.
// A stalled receiver holds the result register; the emit and finish steps
// wait for it, and a new item is taken whenever the sequencer is idle.
// Reset clears stream state and halt; table contents stay undefined until
// loaded. entry_count resets to 0 and longest_code to 16.
// ----------------------------------------------------------------------------
module prefix_code_table_decoder #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pctd_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pctd_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [8:0]         cfg_data_i
);
  import pctd_pkg::*;

  localparam int Aw = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int Pw = MAX_CODE_BITS + 8;       // pending bit window
  localparam int Cw = $clog2(Pw + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;       // begin a symbol search
  localparam logic [2:0] S_SCAN  = 3'd2;       // read address issued
  localparam logic [2:0] S_END   = 3'd3;       // length scan finished
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [8:0]    ecount_q;
  logic [4:0]    lcode_q;
  logic [Pw-1:0] pbits_q, pbits_d;
  logic [Cw-1:0] pcnt_q, pcnt_d;
  logic          halt_q, halt_d;
  logic          last_q, last_d;
  logic [3:0]    nsym_q, nsym_d;
  logic [4:0]    len_q, len_d;
  logic [8:0]    addr_q, addr_d;
  logic          rd_q, rd_d;          // a read result arrives this cycle
  logic          hit_q, hit_d;
  logic [7:0]    hsym_q, hsym_d;
  logic          pend_q, pend_d;      // a decoded symbol is held back
  logic [7:0]    psym_q, psym_d;
  logic          ovalid_q, ovalid_d;
  out_item_t     odata_q, odata_d;
  logic          stat_q, stat_d;      // status result still owed

  logic [8:0]  lim;
  logic [4:0]  lmax;
  logic [28:0] rdata;
  logic [15:0] mask16;
  logic [15:0] prefix;
  logic        match;
  logic        in_acc;

  assign lim  = (ecount_q > 9'(TABLE_ENTRIES)) ? 9'(TABLE_ENTRIES) : ecount_q;
  assign lmax = (lcode_q > 5'(MAX_CODE_BITS)) ? 5'(MAX_CODE_BITS) : lcode_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // the next address is registered inside the memory, so rdata follows addr_q
  pctd_table #(.Depth(TABLE_ENTRIES), .Aw(Aw)) u_table (
    .clk_i  (clk_i),
    .we_i   (in_acc && in_data_i.action == ACT_LOAD &&
             {1'b0, in_data_i.entry_index} < 9'(TABLE_ENTRIES)),
    .waddr_i(Aw'(in_data_i.entry_index)),
    .wdata_i({in_data_i.code_bits, in_data_i.code_length, in_data_i.symbol_byte}),
    .raddr_i(Aw'(addr_d)),
    .rdata_o(rdata)
  );

  // Prefix of len_q bits from the top of the pending window
  always_comb begin
    logic [Pw-1:0] sh;
    sh     = pbits_q >> (pcnt_q - Cw'(len_q));
    mask16 = 16'((17'd1 << len_q) - 17'd1);
    prefix = 16'(sh) & mask16;
  end
  assign match = (rdata[12:8] == len_q) && ((rdata[28:13] & mask16) == prefix);

  always_comb begin
    state_d  = state_q;
    pbits_d  = pbits_q;
    pcnt_d   = pcnt_q;
    halt_d   = halt_q;
    last_d   = last_q;
    nsym_d   = nsym_q;
    len_d    = len_q;
    addr_d   = addr_q;
    rd_d     = 1'b0;
    hit_d    = hit_q;
    hsym_d   = hsym_q;
    pend_d   = pend_q;
    psym_d   = psym_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    stat_d   = stat_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.action == ACT_DATA) begin
          last_d = in_data_i.last_byte;
          nsym_d = '0;
          stat_d = 1'b0;
          if (!halt_q) begin
            pbits_d = Pw'({pbits_q, in_data_i.data_byte});
            pcnt_d  = pcnt_q + Cw'(8);
            state_d = S_START;
          end else begin
            stat_d  = 1'b1;
            state_d = S_FIN;
          end
        end
      end
      S_START: begin
        if (pcnt_q == '0 || nsym_q == 4'd8) begin
          stat_d  = (nsym_q == '0);
          state_d = S_FIN;
        end else if (lmax == '0) begin
          halt_d  = 1'b1;
          stat_d  = 1'b1;
          state_d = S_FIN;
        end else if (pcnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          len_d   = 5'd1;
          addr_d  = '0;
          hit_d   = 1'b0;
          rd_d    = (lim != '0);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_q && match) begin
          hit_d  = 1'b1;
          hsym_d = rdata[7:0];
        end
        if (lim != '0 && addr_q + 9'd1 < lim) begin
          addr_d = addr_q + 9'd1;
          rd_d   = 1'b1;
        end else begin
          state_d = S_END;
        end
      end
      S_END: begin
        if (hit_q) begin
          pcnt_d  = pcnt_q - Cw'(len_q);
          pbits_d = pbits_q & ((Pw'(1) << (pcnt_q - Cw'(len_q))) - Pw'(1));
          state_d = S_EMIT;
        end else if (len_q == lmax) begin
          halt_d  = 1'b1;
          stat_d  = 1'b1;
          state_d = S_FIN;
        end else if (Cw'(len_q) + Cw'(1) > pcnt_q) begin
          if (last_q) begin
            halt_d = 1'b1;
            stat_d = 1'b1;
          end else begin
            stat_d = (nsym_q == '0);
          end
          state_d = S_FIN;
        end else begin
          len_d   = len_q + 5'd1;
          addr_d  = '0;
          rd_d    = (lim != '0);
          state_d = S_SCAN;
        end
      end
      S_EMIT: begin
        // the previous symbol is now known not to be the last one
        if (!pend_q || !ovalid_q || out_ready_i) begin
          if (pend_q) begin
            ovalid_d = 1'b1;
            odata_d  = '{out_symbol: psym_q, has_symbol: 1'b1, halted: 1'b0,
                         last_in_run: 1'b0};
          end
          pend_d  = 1'b1;
          psym_d  = hsym_q;
          nsym_d  = nsym_q + 4'd1;
          state_d = S_START;
        end
      end
      S_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          if (pend_q) begin
            ovalid_d = 1'b1;
            odata_d  = '{out_symbol: psym_q, has_symbol: 1'b1, halted: 1'b0,
                         last_in_run: !stat_q};
            pend_d   = 1'b0;
          end else if (stat_q) begin
            ovalid_d = 1'b1;
            odata_d  = '{out_symbol: 8'd0, has_symbol: 1'b0, halted: halt_q,
                         last_in_run: 1'b1};
          end
          // with a status result still owed after a symbol, stay in S_FIN to send it
          if (!pend_q || !stat_q) begin
            if (last_q) begin
              pbits_d = '0;
              pcnt_d  = '0;
              halt_d  = 1'b0;
            end
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ecount_q <= '0;
      lcode_q  <= 5'd16;
      pbits_q  <= '0;
      pcnt_q   <= '0;
      halt_q   <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      rd_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      pbits_q  <= pbits_d;
      pcnt_q   <= pcnt_d;
      halt_q   <= halt_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
      rd_q     <= rd_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ENTRY_COUNT) begin
          ecount_q <= cfg_data_i;
        end else begin
          lcode_q <= cfg_data_i[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    nsym_q  <= nsym_d;
    len_q   <= len_d;
    addr_q  <= addr_d;
    hit_q   <= hit_d;
    hsym_q  <= hsym_d;
    psym_q  <= psym_d;
    odata_q <= odata_d;
    stat_q  <= stat_d;
  end
endmodule

// ----- hdl/pctd_checker.sv -----
// ----------------------------------------------------------------------------
// pctd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pctd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pctd_pkg::out_item_t out_data_o
);
  import pctd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  a_sym_not_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_symbol |-> !out_data_o.halted)
    else $error("symbol result flagged halted");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_symbol |-> out_data_o.last_in_run)
    else $error("status result not final");
endmodule

bind prefix_code_table_decoder pctd_checker u_pctd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
